// File: hw/rtl/mbps_pkg.sv
// Package for the masked byte pattern scanner: sizes, register indexes and
// the types shared by the window compare unit and the top level.
// No dependencies.
`default_nettype none

package mbps_pkg;

    localparam int MAX_PATTERN   = 20;
    localparam int POSITION_BITS = 32;
    localparam int LEN_BITS      = 5;
    localparam int ADDR_BITS     = 64;
    localparam int DISP_BITS     = 32;
    localparam int ADJ_BITS      = 34;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 64;

    typedef logic [CFG_IDX_BITS-1:0] cfg_index_t;

    // Configuration register indexes
    localparam cfg_index_t CFG_PAT_LOW  = 3'd0;
    localparam cfg_index_t CFG_PAT_MID  = 3'd1;
    localparam cfg_index_t CFG_PAT_HIGH = 3'd2;
    localparam cfg_index_t CFG_CARE     = 3'd3;
    localparam cfg_index_t CFG_LENGTH   = 3'd4;
    localparam cfg_index_t CFG_OFFSET   = 3'd5;
    localparam cfg_index_t CFG_BASE     = 3'd6;

    typedef logic [MAX_PATTERN-1:0][7:0] pattern_t;

    // Result of the window compare for the byte being transferred
    typedef struct packed {
        logic                 hit;
        logic [DISP_BITS-1:0] disp;
    } scan_t;

endpackage

`default_nettype wire

// File: hw/rtl/mbps_window.sv
// Byte window of the scanner: shift register of recent bytes, masked
// compare against the pattern and displacement extraction.
// Depends on mbps_pkg.
`default_nettype none

module mbps_window (
    input  wire logic                           clk,
    input  wire logic                           shift_en,
    input  wire logic [7:0]                     data_byte,
    input  wire mbps_pkg::pattern_t             pattern,
    input  wire logic [mbps_pkg::MAX_PATTERN-1:0] care_mask,
    input  wire logic [mbps_pkg::LEN_BITS-1:0]  eff_len,
    input  wire logic [mbps_pkg::LEN_BITS-1:0]  offset,
    output mbps_pkg::scan_t                     scan
);

    mbps_pkg::pattern_t window_reg;
    mbps_pkg::pattern_t window_next;
    mbps_pkg::pattern_t aligned;

    // Shift the new byte in at index 0
    always_comb
    begin
        window_next = {window_reg[mbps_pkg::MAX_PATTERN-2:0], data_byte};
    end

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            window_reg <= window_next;
        end
    end

    // Line up the window so that pattern byte j sits at index j
    always_comb
    begin
        for (int j = 0; j < mbps_pkg::MAX_PATTERN; j++)
        begin
            if (mbps_pkg::LEN_BITS'(j) < eff_len)
            begin
                aligned[j] = window_next[eff_len - mbps_pkg::LEN_BITS'(1)
                                         - mbps_pkg::LEN_BITS'(j)];
            end
            else
            begin
                aligned[j] = 8'h00;
            end
        end
    end

    // Masked compare over the bytes in use
    always_comb
    begin
        scan.hit = 1'b1;
        for (int j = 0; j < mbps_pkg::MAX_PATTERN; j++)
        begin
            if (care_mask[j] && (mbps_pkg::LEN_BITS'(j) < eff_len)
                && (aligned[j] != pattern[j]))
            begin
                scan.hit = 1'b0;
            end
        end
    end

    // Pick the four displacement bytes, zero beyond the pattern length
    always_comb
    begin
        logic [mbps_pkg::LEN_BITS:0] idx;
        for (int i = 0; i < 4; i++)
        begin
            idx = {1'b0, offset} + (mbps_pkg::LEN_BITS + 1)'(i);
            if (idx < {1'b0, eff_len})
            begin
                scan.disp[8*i +: 8] = aligned[idx[mbps_pkg::LEN_BITS-1:0]];
            end
            else
            begin
                scan.disp[8*i +: 8] = 8'h00;
            end
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/masked_byte_pattern_scanner.sv
// Masked byte pattern scanner: takes one byte per cycle unless stalled and
// reports the first masked pattern match of a region (or not found at its
// last byte). A result passes the stage 2 and output registers; throughput
// is one byte per cycle while not stalled. The window compare runs in the
// cycle of the transfer, the address sum in the stage after it.
// Reset: rst_n clears the configuration, region state and valid bits;
// the byte window and the pipeline data registers are not cleared.
`default_nettype none

module masked_byte_pattern_scanner (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_write,
    input  wire mbps_pkg::cfg_index_t               cfg_index,
    input  wire logic [mbps_pkg::CFG_DATA_BITS-1:0] cfg_data,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic [7:0]                         data_byte,
    input  wire logic                               last_byte,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic                                    found,
    output logic [mbps_pkg::ADDR_BITS-1:0]          match_address
);

    localparam int LB = mbps_pkg::LEN_BITS;
    localparam int PB = mbps_pkg::POSITION_BITS;
    localparam int AB = mbps_pkg::ADDR_BITS;
    localparam int DB = mbps_pkg::DISP_BITS;
    localparam int JB = mbps_pkg::ADJ_BITS;

    // Configuration registers
    logic [63:0]                      pat_low_reg;
    logic [63:0]                      pat_mid_reg;
    logic [31:0]                      pat_high_reg;
    logic [mbps_pkg::MAX_PATTERN-1:0] care_reg;
    logic [LB-1:0]                    length_reg;
    logic [LB-1:0]                    offset_reg;
    logic [AB-1:0]                    base_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_low_reg  <= '0;
            pat_mid_reg  <= '0;
            pat_high_reg <= '0;
            care_reg     <= '0;
            length_reg   <= LB'(1);
            offset_reg   <= '0;
            base_reg     <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                mbps_pkg::CFG_PAT_LOW:  pat_low_reg  <= cfg_data;
                mbps_pkg::CFG_PAT_MID:  pat_mid_reg  <= cfg_data;
                mbps_pkg::CFG_PAT_HIGH: pat_high_reg <= cfg_data[31:0];
                mbps_pkg::CFG_CARE:     care_reg     <= cfg_data[mbps_pkg::MAX_PATTERN-1:0];
                mbps_pkg::CFG_LENGTH:   length_reg   <= cfg_data[LB-1:0];
                mbps_pkg::CFG_OFFSET:   offset_reg   <= cfg_data[LB-1:0];
                mbps_pkg::CFG_BASE:     base_reg     <= cfg_data;
                default:                ;
            endcase
        end
    end

    // Clamp the pattern length to 1..MAX_PATTERN
    logic [LB-1:0] eff_len;
    logic [LB-1:0] len_m1;

    always_comb
    begin
        if (length_reg == '0)
        begin
            eff_len = LB'(1);
        end
        else if (length_reg > LB'(mbps_pkg::MAX_PATTERN))
        begin
            eff_len = LB'(mbps_pkg::MAX_PATTERN);
        end
        else
        begin
            eff_len = length_reg;
        end
        len_m1 = eff_len - LB'(1);
    end

    // Handshake and pipeline advance
    logic s2_valid_reg;
    logic out_valid_reg;
    logic out_load;
    logic s2_advance;
    logic accept;

    assign out_load   = !out_valid_reg || !out_stall;
    assign s2_advance = !s2_valid_reg || out_load;
    assign in_stall   = !s2_advance;
    assign accept     = in_valid && !in_stall;

    // Window compare
    mbps_pkg::scan_t scan;

    mbps_window u_window (
        .clk       (clk),
        .shift_en  (accept),
        .data_byte (data_byte),
        .pattern   ({pat_high_reg, pat_mid_reg, pat_low_reg}),
        .care_mask (care_reg),
        .eff_len   (eff_len),
        .offset    (offset_reg),
        .scan      (scan)
    );

    // Region state
    logic [PB-1:0] position_reg;
    logic [PB-1:0] position_next;
    logic          matched_reg;
    logic          matched_next;
    logic          hit;
    logic          emit;

    always_comb
    begin
        hit  = !matched_reg && (position_reg >= PB'(len_m1)) && scan.hit;
        emit = accept && (hit || (last_byte && !matched_reg));

        position_next = position_reg;
        matched_next  = matched_reg;
        if (accept)
        begin
            if (last_byte)
            begin
                position_next = '0;
                matched_next  = 1'b0;
            end
            else
            begin
                matched_next = matched_reg || hit;
                if (position_reg != '1)
                begin
                    position_next = position_reg + PB'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg <= '0;
            matched_reg  <= 1'b0;
        end
        else
        begin
            position_reg <= position_next;
            matched_reg  <= matched_next;
        end
    end

    // Stage 2: hold match start and displacement adjustment
    logic          s2_found_reg;
    logic [PB-1:0] s2_start_reg;
    logic [JB-1:0] s2_adj_reg;
    logic [JB-1:0] adj_next;

    always_comb
    begin
        if (offset_reg != '0)
        begin
            adj_next = {{(JB-DB){scan.disp[DB-1]}}, scan.disp} + JB'(offset_reg) + JB'(4);
        end
        else
        begin
            adj_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_advance)
        begin
            s2_valid_reg <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            s2_found_reg <= hit;
            s2_start_reg <= position_reg - PB'(len_m1);
            s2_adj_reg   <= adj_next;
        end
    end

    // Output register: resolve the address
    logic          found_reg;
    logic [AB-1:0] addr_reg;
    logic [AB-1:0] addr_next;

    always_comb
    begin
        if (s2_found_reg)
        begin
            addr_next = base_reg + AB'(s2_start_reg)
                        + {{(AB-JB){s2_adj_reg[JB-1]}}, s2_adj_reg};
        end
        else
        begin
            addr_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load && s2_valid_reg)
        begin
            found_reg <= s2_found_reg;
            addr_reg  <= addr_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign found         = found_reg;
    assign match_address = addr_reg;

endmodule

`default_nettype wire

// File: hw/rtl/mbps_checker.sv
// Port-level checks for the masked byte pattern scanner, bound to the top.
// Depends on mbps_pkg and masked_byte_pattern_scanner.
`default_nettype none

module mbps_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          in_valid,
    input wire logic                          in_stall,
    input wire logic                          out_valid,
    input wire logic                          out_stall,
    input wire logic                          found,
    input wire logic [mbps_pkg::ADDR_BITS-1:0] match_address
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(found) && $stable(match_address))
        else $error("stalled result changed");

    // Report not found with a zero address
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> match_address == '0)
        else $error("not-found result carries an address");

    // Stall the input only behind a stalled output
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output back-pressure");

    // A fresh result follows an input transfer that passed through stage 2
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
        else $error("result without a matching input transfer");

endmodule

bind masked_byte_pattern_scanner mbps_checker u_mbps_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .found         (found),
    .match_address (match_address)
);

`default_nettype wire

// File: dv/testbench.sv
// Testbench for the masked byte pattern scanner: directed and random byte
// regions, checked against a scoreboard class that predicts every result.
// Depends on mbps_pkg and masked_byte_pattern_scanner.
module testbench;
    import mbps_pkg::*;

    localparam int RANDOM_BYTES  = 1100;
    localparam int SETTLE_CYCLES = 6;
    localparam int HOLD_CYCLES   = 400;
    localparam int QUIET_LIMIT   = 4000;

    typedef struct {
        logic                 found;
        logic [ADDR_BITS-1:0] address;
    } scan_outcome_t;

    // Clamp the length register the way the scanner does
    function automatic int effective_length(input logic [LEN_BITS-1:0] raw);
        if (raw == 0)
        begin
            return 1;
        end
        if (raw > MAX_PATTERN)
        begin
            return MAX_PATTERN;
        end
        return int'(raw);
    endfunction

    class scan_scoreboard;
        logic [63:0]              pat_low;
        logic [63:0]              pat_mid;
        logic [31:0]              pat_high;
        logic [MAX_PATTERN-1:0]   care;
        logic [LEN_BITS-1:0]      length_reg;
        logic [LEN_BITS-1:0]      offset_reg;
        logic [ADDR_BITS-1:0]     base;
        logic [7:0]               window [MAX_PATTERN];
        logic [POSITION_BITS-1:0] position;
        bit                       matched;
        scan_outcome_t            outcomes_due [$];
        int                       errors;
        int                       bytes_seen;
        int                       regions_seen;
        int                       hits_checked;
        int                       misses_checked;

        function new();
            pat_low        = '0;
            pat_mid        = '0;
            pat_high       = '0;
            care           = '0;
            length_reg     = 5'd1;
            offset_reg     = '0;
            base           = '0;
            position       = '0;
            matched        = 1'b0;
            errors         = 0;
            bytes_seen     = 0;
            regions_seen   = 0;
            hits_checked   = 0;
            misses_checked = 0;
            foreach (window[k])
            begin
                window[k] = 8'h00;
            end
        endfunction

        function int span();
            return effective_length(length_reg);
        endfunction

        function logic [7:0] pattern_byte(input int j);
            logic [8*MAX_PATTERN-1:0] all;
            all = {pat_high, pat_mid, pat_low};
            return all[8*j +: 8];
        endfunction

        // Byte of the newest window that lines up with pattern index j
        function logic [7:0] window_byte(input int len, input int j);
            if (j >= len)
            begin
                return 8'h00;
            end
            return window[len-1-j];
        endfunction

        function void apply_register(input cfg_index_t idx, input logic [63:0] value);
            case (idx)
                CFG_PAT_LOW:  pat_low    = value;
                CFG_PAT_MID:  pat_mid    = value;
                CFG_PAT_HIGH: pat_high   = value[31:0];
                CFG_CARE:     care       = value[MAX_PATTERN-1:0];
                CFG_LENGTH:   length_reg = value[LEN_BITS-1:0];
                CFG_OFFSET:   offset_reg = value[LEN_BITS-1:0];
                CFG_BASE:     base       = value;
                default:      ;
            endcase
        endfunction

        // Advance the window by one transferred byte and queue any result it causes
        function void predict_byte(input logic [7:0] value, input logic is_last);
            int                   len;
            int                   j;
            bit                   hit;
            logic [31:0]          raw;
            logic [ADDR_BITS-1:0] addr;
            len = span();
            bytes_seen++;
            for (j = MAX_PATTERN - 1; j > 0; j--)
            begin
                window[j] = window[j-1];
            end
            window[0] = value;

            if (!matched && position >= POSITION_BITS'(len - 1))
            begin
                hit = 1'b1;
                for (j = 0; j < len; j++)
                begin
                    if (care[j] && window_byte(len, j) != pattern_byte(j))
                    begin
                        hit = 1'b0;
                    end
                end
                if (hit)
                begin
                    addr = base + (64'(position) - 64'(len - 1));
                    // Resolve the little-endian signed displacement
                    if (offset_reg != 0)
                    begin
                        raw = '0;
                        for (j = 0; j < 4; j++)
                        begin
                            raw[8*j +: 8] = window_byte(len, int'(offset_reg) + j);
                        end
                        addr = addr + 64'(offset_reg) + 64'd4 + {{32{raw[31]}}, raw};
                    end
                    outcomes_due.push_back('{1'b1, addr});
                    matched = 1'b1;
                end
            end

            if (is_last)
            begin
                if (!matched)
                begin
                    outcomes_due.push_back('{1'b0, '0});
                end
                regions_seen++;
                position = '0;
                matched  = 1'b0;
            end
            else if (position != '1)
            begin
                position = position + 1'b1;
            end
        endfunction

        function void check_outcome(input logic got_found, input logic [ADDR_BITS-1:0] got_addr);
            scan_outcome_t want;
            if (outcomes_due.size() == 0)
            begin
                $display("%0t: result with none expected: found=%0b address=%h",
                         $time, got_found, got_addr);
                errors++;
                return;
            end
            want = outcomes_due.pop_front();
            if (got_found !== want.found)
            begin
                $display("%0t: found mismatch: expected %0b, got %0b",
                         $time, want.found, got_found);
                errors++;
            end
            if (got_addr !== want.address)
            begin
                $display("%0t: match_address mismatch: expected %h, got %h",
                         $time, want.address, got_addr);
                errors++;
            end
            if (want.found)
            begin
                hits_checked++;
            end
            else
            begin
                misses_checked++;
            end
        endfunction
    endclass

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     cfg_write;
    cfg_index_t               cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;
    logic                     in_valid;
    logic                     in_stall;
    logic [7:0]               data_byte;
    logic                     last_byte;
    logic                     out_valid;
    logic                     out_stall;
    logic                     found;
    logic [ADDR_BITS-1:0]     match_address;

    logic                     steady;
    logic                     hold_request;
    int                       settings_used;

    scan_scoreboard sb = new();

    masked_byte_pattern_scanner dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .data_byte     (data_byte),
        .last_byte     (last_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .found         (found),
        .match_address (match_address)
    );

    always #1 clk = ~clk;

    // Hold the write enable high across one register write
    task automatic put_reg(input cfg_index_t idx, input logic [63:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        sb.apply_register(idx, value);
    endtask

    task automatic program_regs(input logic [63:0] low_v, input logic [63:0] mid_v,
                                input logic [63:0] high_v, input logic [63:0] care_v,
                                input logic [63:0] len_v, input logic [63:0] off_v,
                                input logic [63:0] base_v);
        put_reg(CFG_PAT_LOW, low_v);
        put_reg(CFG_PAT_MID, mid_v);
        put_reg(CFG_PAT_HIGH, high_v);
        put_reg(CFG_CARE, care_v);
        put_reg(CFG_LENGTH, len_v);
        put_reg(CFG_OFFSET, off_v);
        put_reg(CFG_BASE, base_v);
        cfg_write <= 1'b0;
        settings_used++;
    endtask

    // Offer one byte, idling now and then, and hold it until the transfer
    task automatic send_byte(input logic [7:0] value, input logic is_last);
        if (!steady && $urandom_range(99) < 17)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= value;
        last_byte <= is_last;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        sb.predict_byte(value, is_last);
    endtask

    // Build a region, often with a planted (sometimes spoiled) pattern copy
    task automatic send_region(input int rlen);
        logic [7:0] region [$];
        int         len;
        int         at;
        int         j;
        int         k;
        len = sb.span();
        for (j = 0; j < rlen; j++)
        begin
            if ($urandom_range(99) < 40)
            begin
                region.push_back(sb.pattern_byte($urandom_range(len - 1)));
            end
            else
            begin
                region.push_back(8'($urandom));
            end
        end
        if (rlen >= len && $urandom_range(99) < 65)
        begin
            at = ($urandom_range(99) < 25) ? rlen - len : int'($urandom_range(rlen - len));
            for (j = 0; j < len; j++)
            begin
                if (sb.care[j])
                begin
                    region[at+j] = sb.pattern_byte(j);
                end
            end
            if ($urandom_range(99) < 20)
            begin
                k = at + int'($urandom_range(len - 1));
                region[k] = region[k] ^ 8'(1 << $urandom_range(7));
            end
        end
        for (j = 0; j < rlen; j++)
        begin
            send_byte(region[j], j == rlen - 1);
        end
    endtask

    // Pause the sender until every result is in and the pipeline is empty
    task automatic drain_pipeline();
        in_valid <= 1'b0;
        while (sb.outcomes_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic random_setup();
        logic [63:0] len_v;
        logic [63:0] off_v;
        logic [63:0] care_v;
        logic [63:0] base_v;
        int          r;
        int          len;
        len_v = {$urandom, $urandom};
        r = $urandom_range(99);
        if (r < 10)
        begin
            len_v[4:0] = 5'd0;
        end
        else if (r < 22)
        begin
            len_v[4:0] = 5'(MAX_PATTERN);
        end
        else if (r < 30)
        begin
            len_v[4:0] = 5'($urandom_range(21, 31));
        end
        else if (r < 50)
        begin
            len_v[4:0] = 5'($urandom_range(9, 19));
        end
        else
        begin
            len_v[4:0] = 5'($urandom_range(1, 8));
        end
        len = effective_length(len_v[4:0]);

        // Mostly keep the displacement inside the pattern, sometimes not
        off_v = {$urandom, $urandom};
        r = $urandom_range(99);
        if (r < 45)
        begin
            off_v[4:0] = 5'd0;
        end
        else if (r < 85 && len >= 5)
        begin
            off_v[4:0] = 5'($urandom_range(1, len - 4));
        end
        else
        begin
            off_v[4:0] = 5'($urandom_range(1, 31));
        end

        care_v = {$urandom, $urandom};
        r = $urandom_range(99);
        if (r < 15)
        begin
            care_v[19:0] = '1;
        end
        else if (r < 25)
        begin
            care_v[19:0] = '0;
        end
        else if (r >= 60)
        begin
            care_v[19:0] = care_v[19:0] & 20'($urandom) & 20'($urandom);
        end

        r = $urandom_range(99);
        if (r < 12)
        begin
            base_v = '0;
        end
        else if (r < 24)
        begin
            base_v = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(40));
        end
        else
        begin
            base_v = {$urandom, $urandom};
        end

        program_regs({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                     care_v, len_v, off_v, base_v);
    endtask

    initial
    begin : stimulus
        int phase;
        int r;
        int k;
        int rlen;
        int regions;
        int random_start;
        rst_n         = 1'b0;
        cfg_write     = 1'b0;
        cfg_index     = CFG_PAT_LOW;
        cfg_data      = '0;
        in_valid      = 1'b0;
        data_byte     = 8'h00;
        last_byte     = 1'b0;
        steady        = 1'b0;
        hold_request  = 1'b0;
        settings_used = 1;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: length one with no care bits matches the first byte
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        drain_pipeline();

        // Zero length acts as one; region without a match; address wraps
        program_regs(64'hFF, '0, '0, 64'h1, 64'h0, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h12, 1'b0);
        send_byte(8'hFF, 1'b1);
        drain_pipeline();

        // Match on the window ending at the last byte, negative displacement,
        // care bits set beyond the pattern length
        program_regs(64'h0000_8000_0000_55AA, '1, '1, 64'hFFFF_FFFF_FFFF_FFC3,
                     64'h6, 64'h2, 64'h1000);
        send_byte(8'h01, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h55, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h80, 1'b1);
        drain_pipeline();

        // Displacement running past the pattern end; later bytes give nothing
        program_regs(64'h7F, '1, '1, 64'h1, 64'h4, 64'h3, 64'h0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'h11, 1'b0);
        send_byte(8'h22, 1'b0);
        send_byte(8'h33, 1'b0);
        send_byte(8'h7F, 1'b0);
        send_byte(8'hFF, 1'b1);
        drain_pipeline();

        random_start = sb.bytes_seen;
        phase = 0;
        while (sb.bytes_seen - random_start < RANDOM_BYTES)
        begin
            if (phase == 3)
            begin
                // One result per short region while the receiver holds off
                program_regs({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                             64'h0, 64'h1, 64'h0, {$urandom, $urandom});
                hold_request = 1'b1;
                for (k = 0; k < 80; k++)
                begin
                    send_region($urandom_range(1, 2));
                end
            end
            else
            begin
                random_setup();
                steady = (phase == 7);
                regions = steady ? 14 : $urandom_range(2, 8);
                for (k = 0; k < regions; k++)
                begin
                    r = $urandom_range(99);
                    if (r < 10)
                    begin
                        rlen = $urandom_range(1, 3);
                    end
                    else if (r < 88)
                    begin
                        rlen = $urandom_range(sb.span(), 2 * sb.span() + 6);
                    end
                    else
                    begin
                        rlen = $urandom_range(30, 70);
                    end
                    send_region(rlen);
                end
            end
            drain_pipeline();
            steady = 1'b0;
            phase++;
        end

        $display("Scanned %0d bytes in %0d regions under %0d register settings,",
                 sb.bytes_seen, sb.regions_seen, settings_used);
        $display("with a long output hold-off; %0d matches and %0d not-found results checked.",
                 sb.hits_checked, sb.misses_checked);
        if (sb.errors == 0 && sb.outcomes_due.size() == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Take results and drive the output stall
    initial
    begin : receiver
        int hold_left;
        hold_left = 0;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid === 1'b1 && !out_stall)
            begin
                sb.check_outcome(found, match_address);
            end
            if (hold_request)
            begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= !steady && ($urandom_range(99) < 17);
            end
        end
    end

    // End the run when nothing has moved for too long
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || cfg_write || (in_valid && !in_stall) ||
                (out_valid === 1'b1 && !out_stall))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

endmodule
